@@ rtl/serial_bank_switch_timer_irq_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the serial bank switch timer block
// Simulation builds check the properties; synthesis builds see empty macros.
// ---------------------------------------------------------------------------
`ifndef SERIAL_BANK_SWITCH_TIMER_IRQ_ASSERT_SVH
`define SERIAL_BANK_SWITCH_TIMER_IRQ_ASSERT_SVH
`ifndef SYNTHESIS
`define SBST_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SBST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SBST_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define SBST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/sbst_pkg.sv @@
// ---------------------------------------------------------------------------
// sbst_pkg
// Types and fixed constants of the serial bank switch timer block.
// ---------------------------------------------------------------------------
`default_nettype none

package sbst_pkg;

    typedef logic [4:0] ctrl_word_t;

    // Operation codes of an input word.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Control register indexes.
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_TIMER = 2'd1;
    localparam logic [1:0] REG_BANK  = 2'd3;

    // Program bank modes from register 0 bits 3:2.
    localparam logic [1:0] MODE_FIX_HIGH = 2'd3;
    localparam logic [1:0] MODE_FIX_LOW  = 2'd2;

    localparam ctrl_word_t  REG0_RESET    = 5'd12;
    localparam logic [3:0]  DIP_RESET     = 4'hE;
    localparam logic [2:0]  LAST_BIT_POS  = 3'd4;
    localparam logic [29:0] TIMER_LIMIT   = 30'h3E00_0000;

endpackage

`default_nettype wire

@@ rtl/serial_bank_switch_timer_irq.sv @@
// ---------------------------------------------------------------------------
// serial_bank_switch_timer_irq
// Serially loaded bank controller with a cycle-counting interrupt timer.
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  input    | in_valid / in_ready    | operation, reg_select, write_data,
//           |                        | cycle_count
//  result   | out_valid / out_ready  | bank_low, bank_high, mirroring,
//           |                        | irq_level
//  config   | cfg_valid / cfg_ready  | dip_switch
//
// Each word updates the state and registers its result, so one word is
// accepted per cycle while the result register is empty or drained.
// The result appears in the cycle after acceptance. A stalled result holds the
// input back only while it is still waiting; ready then drops.
// Reset loads the power-on register values at once; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

`include "serial_bank_switch_timer_irq_assert.svh"

module serial_bank_switch_timer_irq
    import sbst_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       operation,
    input  wire logic [1:0] reg_select,
    input  wire logic [7:0] write_data,
    input  wire logic [7:0] cycle_count,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [3:0]      bank_low,
    output logic [3:0]      bank_high,
    output logic [1:0]      mirroring,
    output logic            irq_level,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [3:0] dip_switch
);

    ctrl_word_t  ctrl_reg [4];
    ctrl_word_t  ctrl_next [4];
    logic [4:0]  shift_buf_reg, shift_buf_next;
    logic [2:0]  shift_pos_reg, shift_pos_next;
    logic [1:0]  last_target_reg, last_target_next;
    logic [29:0] timer_count_reg, timer_count_next;
    logic        irq_pending_reg, irq_pending_next;
    logic [3:0]  dip_reg;
    logic        out_valid_reg;
    logic [3:0]  bank_low_reg, bank_high_reg;
    logic [1:0]  mirroring_reg;
    logic        irq_level_reg;

    logic        in_accept;
    logic [4:0]  buf_work;
    logic [2:0]  pos_work;
    logic [29:0] timer_sum;
    logic [29:0] timer_cmp;
    logic [3:0]  bank_low_next, bank_high_next;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // State update for one accepted word.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            ctrl_next[i] = ctrl_reg[i];
        end
        shift_buf_next   = shift_buf_reg;
        shift_pos_next   = shift_pos_reg;
        last_target_next = last_target_reg;
        timer_count_next = timer_count_reg;
        irq_pending_next = irq_pending_reg;
        buf_work         = shift_buf_reg;
        pos_work         = shift_pos_reg;
        // The count stays below the limit, so adding one tick cannot overflow.
        timer_sum        = timer_count_reg + {22'b0, cycle_count};
        timer_cmp        = timer_sum | {1'b0, dip_reg, 25'b0};

        if (in_accept)
        begin
            if (operation == OP_WRITE)
            begin
                if (write_data[7])
                begin
                    shift_buf_next = '0;
                    shift_pos_next = '0;
                end
                else
                begin
                    // A new target register starts a fresh sequence.
                    if (reg_select != last_target_reg)
                    begin
                        buf_work = '0;
                        pos_work = '0;
                    end
                    last_target_next = reg_select;
                    buf_work = buf_work | (5'(write_data[0]) << pos_work);
                    if (pos_work == LAST_BIT_POS)
                    begin
                        ctrl_next[reg_select] = buf_work;
                        shift_buf_next = '0;
                        shift_pos_next = '0;
                        if (reg_select == REG_TIMER && buf_work[4])
                        begin
                            timer_count_next = '0;
                            irq_pending_next = 1'b0;
                        end
                    end
                    else
                    begin
                        shift_buf_next = buf_work;
                        shift_pos_next = pos_work + 3'd1;
                    end
                end
            end
            else if (!ctrl_reg[REG_TIMER][4])
            begin
                if (timer_cmp >= TIMER_LIMIT)
                begin
                    timer_count_next = '0;
                    irq_pending_next = 1'b1;
                end
                else
                begin
                    timer_count_next = timer_sum;
                end
            end
        end
    end

    // Program bank decode from the updated registers.
    always_comb
    begin
        if (ctrl_next[REG_TIMER][3])
        begin
            case (ctrl_next[REG_MODE][3:2])
                MODE_FIX_HIGH:
                begin
                    bank_low_next  = {1'b1, ctrl_next[REG_BANK][2:0]};
                    bank_high_next = 4'hF;
                end
                MODE_FIX_LOW:
                begin
                    bank_low_next  = 4'h8;
                    bank_high_next = {1'b1, ctrl_next[REG_BANK][2:0]};
                end
                default:
                begin
                    bank_low_next  = {1'b1, ctrl_next[REG_BANK][2:1], 1'b0};
                    bank_high_next = {1'b1, ctrl_next[REG_BANK][2:1], 1'b1};
                end
            endcase
        end
        else
        begin
            bank_low_next  = {1'b0, ctrl_next[REG_TIMER][2:1], 1'b0};
            bank_high_next = {1'b0, ctrl_next[REG_TIMER][2:1], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg[0]     <= REG0_RESET;
            ctrl_reg[1]     <= '0;
            ctrl_reg[2]     <= '0;
            ctrl_reg[3]     <= '0;
            shift_buf_reg   <= '0;
            shift_pos_reg   <= '0;
            last_target_reg <= '0;
            timer_count_reg <= '0;
            irq_pending_reg <= 1'b0;
            dip_reg         <= DIP_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                ctrl_reg[i] <= ctrl_next[i];
            end
            shift_buf_reg   <= shift_buf_next;
            shift_pos_reg   <= shift_pos_next;
            last_target_reg <= last_target_next;
            timer_count_reg <= timer_count_next;
            irq_pending_reg <= irq_pending_next;
            if (cfg_valid && cfg_ready)
            begin
                dip_reg <= dip_switch;
            end
            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            bank_low_reg  <= bank_low_next;
            bank_high_reg <= bank_high_next;
            mirroring_reg <= ctrl_next[REG_MODE][1:0];
            irq_level_reg <= irq_pending_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign bank_low  = bank_low_reg;
    assign bank_high = bank_high_reg;
    assign mirroring = mirroring_reg;
    assign irq_level = irq_level_reg;

    `SBST_ASSERT_IMPLY(a_shift_pos_range, clk, rst_n, 1'b1, shift_pos_reg <= LAST_BIT_POS, "shift position beyond last bit")
    `SBST_ASSERT_IMPLY(a_timer_below_limit, clk, rst_n, 1'b1, timer_count_reg < TIMER_LIMIT, "timer count reached the limit without clearing")
    `SBST_ASSERT_IMPLY(a_timer_held_when_stopped, clk, rst_n, ctrl_reg[REG_TIMER][4], timer_count_reg == 30'd0, "timer counting while stopped")
    `SBST_ASSERT_NEXT(a_state_idle_hold, clk, rst_n, !in_accept, $stable(timer_count_reg) && $stable(irq_pending_reg), "timer state moved without an accepted word")
    `SBST_ASSERT_IMPLY(a_irq_rise_on_tick, clk, rst_n, $rose(irq_pending_reg), $past(in_accept && operation == OP_TICK), "interrupt raised without a tick")

endmodule

`default_nettype wire
